// ===== hdl/vml_pkg.sv =====
// ----------------------------------------------------------------------------
// vml_pkg
// Shared defaults and types for the velocity magnitude limiter.
// ----------------------------------------------------------------------------
package vml_pkg;

    // Default component width (signed fixed point, two's complement)
    localparam int COMPONENT_WIDTH_DEF = 24;

    // Pipeline control handed to the square-root and divider pipelines and the output stage
    typedef struct packed {
        logic en;     // whole pipeline advances
        logic valid;  // an item enters the first stage
    } t_pipe_ctl;

endpackage
// ----------------------------------------------------------------------------

// ===== hdl/vml_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// vml_sqrt_pipe
// Pipelined integer square root, one result bit per stage. Carries a
// sideband word alongside the data.
// ----------------------------------------------------------------------------
module vml_sqrt_pipe #(
    parameter int COMPONENT_WIDTH = vml_pkg::COMPONENT_WIDTH_DEF,
    parameter int SB_WIDTH        = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vml_pkg::t_pipe_ctl           i_ctl,
    input  logic [2*COMPONENT_WIDTH-1:0] i_x,
    input  logic [SB_WIDTH-1:0]          i_sb,
    output logic                         o_valid,
    output logic [COMPONENT_WIDTH-1:0]   o_root,
    output logic [SB_WIDTH-1:0]          o_sb
);
    import vml_pkg::*;

    localparam int N = COMPONENT_WIDTH;

    // remainder stays at most 2*root, so N+1 bits
    logic [N:0]          w_rem  [0:N];
    logic [N-1:0]        w_root [0:N];
    logic [2*N-1:0]      w_x    [0:N];
    logic [SB_WIDTH-1:0] w_sb   [0:N];
    logic                w_v    [0:N];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = i_x;
    assign w_sb[0]   = i_sb;
    assign w_v[0]    = i_ctl.valid;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N+2:0]        n_rem2;
        logic [N+2:0]        n_trial;
        logic [N+2:0]        n_diff;
        logic                n_ge;
        logic [N:0]          r_rem;
        logic [N-1:0]        r_root;
        logic [2*N-1:0]      r_x;
        logic [SB_WIDTH-1:0] r_sb;
        logic                r_v;

        // trial subtract of (4*root + 1)
        always_comb begin
            n_rem2  = {w_rem[k], w_x[k][2*N-1 -: 2]};
            n_trial = {1'b0, w_root[k], 2'b01};
            n_diff  = n_rem2 - n_trial;
            n_ge    = (n_rem2 >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem  <= n_ge ? n_diff[N:0] : n_rem2[N:0];
                r_root <= {w_root[k][N-2:0], n_ge};
                r_x    <= {w_x[k][2*N-3:0], 2'b00};
                r_sb   <= w_sb[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_x[k+1]    = r_x;
        assign w_sb[k+1]   = r_sb;
        assign w_v[k+1]    = r_v;
    end

    assign o_valid = w_v[N];
    assign o_root  = w_root[N];
    assign o_sb    = w_sb[N];

endmodule
// ----------------------------------------------------------------------------

// ===== hdl/vml_div_pipe.sv =====
// ----------------------------------------------------------------------------
// vml_div_pipe
// Three-lane pipelined restoring divider with a shared divisor, one
// quotient bit per stage. The quotient is known to fit COMPONENT_WIDTH-1
// bits, so only that many steps are taken.
// ----------------------------------------------------------------------------
module vml_div_pipe #(
    parameter int COMPONENT_WIDTH = vml_pkg::COMPONENT_WIDTH_DEF,
    parameter int SB_WIDTH        = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  vml_pkg::t_pipe_ctl                    i_ctl,
    input  logic [2:0][2*COMPONENT_WIDTH-2:0]     i_num,
    input  logic [COMPONENT_WIDTH-1:0]            i_div,
    input  logic [SB_WIDTH-1:0]                   i_sb,
    output logic                                  o_valid,
    output logic [2:0][COMPONENT_WIDTH-2:0]       o_quo,
    output logic [SB_WIDTH-1:0]                   o_sb
);
    import vml_pkg::*;

    localparam int N = COMPONENT_WIDTH;
    localparam int Q = COMPONENT_WIDTH - 1;

    // rest holds unused numerator bits above, quotient bits shift in below
    logic [2:0][N-1:0]   w_rem  [0:Q];
    logic [2:0][Q-1:0]   w_rest [0:Q];
    logic [N-1:0]        w_div  [0:Q];
    logic [SB_WIDTH-1:0] w_sb   [0:Q];
    logic                w_v    [0:Q];

    for (genvar l = 0; l < 3; l++) begin : g_init
        assign w_rem[0][l]  = i_num[l][2*N-2:Q];
        assign w_rest[0][l] = i_num[l][Q-1:0];
    end
    assign w_div[0] = i_div;
    assign w_sb[0]  = i_sb;
    assign w_v[0]   = i_ctl.valid;

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [2:0][N-1:0]   r_rem;
        logic [2:0][Q-1:0]   r_rest;
        logic [N-1:0]        r_div;
        logic [SB_WIDTH-1:0] r_sb;
        logic                r_v;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_div <= w_div[k];
                r_sb  <= w_sb[k];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [N:0] n_rem2;
            logic [N:0] n_diff;
            logic       n_ge;

            // shift in the next numerator bit, try to subtract
            always_comb begin
                n_rem2 = {w_rem[k][l], w_rest[k][l][Q-1]};
                n_diff = n_rem2 - {1'b0, w_div[k]};
                n_ge   = (n_rem2 >= {1'b0, w_div[k]});
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[l]  <= n_ge ? n_diff[N-1:0] : n_rem2[N-1:0];
                    r_rest[l] <= {w_rest[k][l][Q-2:0], n_ge};
                end
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_rest[k+1] = r_rest;
        assign w_div[k+1]  = r_div;
        assign w_sb[k+1]   = r_sb;
        assign w_v[k+1]    = r_v;
    end

    assign o_valid = w_v[Q];
    assign o_quo   = w_rest[Q];
    assign o_sb    = w_sb[Q];

endmodule
// ----------------------------------------------------------------------------

// ===== hdl/velocity_magnitude_limiter.sv =====
// Stages from input transaction to result:
//   three front stages, one square-root stage per root bit, a product stage,
//   one divider stage per quotient bit, and the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the
//   output register is full and not taken.
// Reset: synchronous active-low; clears all valid bits and max_speed to 0.
// ----------------------------------------------------------------------------
// velocity_magnitude_limiter
// Clamps a 3D fixed-point velocity vector to a configured maximum speed,
// keeping its direction; flags vectors that were scaled down.
// ----------------------------------------------------------------------------
module velocity_magnitude_limiter #(
    parameter int COMPONENT_WIDTH = vml_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config
    input  logic                       i_cfg_wr_en,
    input  logic [COMPONENT_WIDTH-2:0] i_cfg_wr_data,   // max_speed
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // vel_x, vel_y, vel_z, zero pad to bytes
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // output stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // out_x, out_y, out_z, zero pad to bytes
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tuser   // was_limited
);
    import vml_pkg::*;

    localparam int N   = COMPONENT_WIDTH;
    localparam int LW  = COMPONENT_WIDTH - 1;
    localparam int Q   = COMPONENT_WIDTH - 1;
    localparam int DW  = ((3*COMPONENT_WIDTH+7)/8)*8;
    localparam int PW  = 2*COMPONENT_WIDTH - 1;
    localparam int SBS = 4 + 6*COMPONENT_WIDTH;
    localparam int SBD = 4 + 3*COMPONENT_WIDTH;

    logic      w_en;
    t_pipe_ctl w_ctl_a;
    t_pipe_ctl w_ctl_s;
    t_pipe_ctl w_ctl_d;

    // config register
    logic [LW-1:0] r_max_speed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= '0;
        end else if (i_cfg_wr_en) begin
            r_max_speed <= i_cfg_wr_data;
        end
    end

    // pipeline advances unless the output holds an untaken result
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage A: sign and magnitude
    logic               r_a_valid;
    logic [2:0]         r_a_neg;
    logic [2:0][N-1:0]  r_a_mag;
    logic [3*N-1:0]     r_a_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_raw <= i_s_axis_tdata[3*N-1:0];
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= i_s_axis_tdata[i*N + N-1];
                r_a_mag[i] <= i_s_axis_tdata[i*N + N-1] ?
                              (~i_s_axis_tdata[i*N +: N] + N'(1)) :
                              i_s_axis_tdata[i*N +: N];
            end
        end
    end

    // stage B: squares and squared limit
    logic                r_b_valid;
    logic [2:0]          r_b_neg;
    logic [2:0][N-1:0]   r_b_mag;
    logic [3*N-1:0]      r_b_raw;
    logic [2:0][2*N-1:0] r_b_sq;
    logic [2*LW-1:0]     r_b_ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_neg <= r_a_neg;
            r_b_mag <= r_a_mag;
            r_b_raw <= r_a_raw;
            r_b_ll  <= r_max_speed * r_max_speed;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= r_a_mag[i] * r_a_mag[i];
            end
        end
    end

    // stage C: sum of squares, compare against limit
    logic              r_c_valid;
    logic              r_c_lim;
    logic [2:0]        r_c_neg;
    logic [2:0][N-1:0] r_c_mag;
    logic [3*N-1:0]    r_c_raw;
    logic [2*N-1:0]    r_c_sum;
    logic [2*N-1:0]    n_c_sum;

    assign n_c_sum = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sum <= n_c_sum;
            r_c_lim <= (r_max_speed != '0) && (n_c_sum > (2*N)'(r_b_ll));
            r_c_neg <= r_b_neg;
            r_c_mag <= r_b_mag;
            r_c_raw <= r_b_raw;
        end
    end

    // square root of the sum
    logic           w_s_valid;
    logic [N-1:0]   w_s_root;
    logic [SBS-1:0] w_s_sb;

    assign w_ctl_s = '{en: w_en, valid: r_c_valid};

    vml_sqrt_pipe #(
        .COMPONENT_WIDTH (N),
        .SB_WIDTH        (SBS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_s),
        .i_x     (r_c_sum),
        .i_sb    ({r_c_lim, r_c_neg, r_c_mag, r_c_raw}),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_sb    (w_s_sb)
    );

    // stage D: numerators |v| * L
    logic              r_d_valid;
    logic              r_d_lim;
    logic [2:0]        r_d_neg;
    logic [3*N-1:0]    r_d_raw;
    logic [N-1:0]      r_d_root;
    logic [2:0][PW-1:0] r_d_prod;
    logic [2:0][N-1:0] w_s_mag;

    assign w_s_mag = w_s_sb[6*N-1:3*N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_lim  <= w_s_sb[6*N+3];
            r_d_neg  <= w_s_sb[6*N +: 3];
            r_d_raw  <= w_s_sb[3*N-1:0];
            r_d_root <= w_s_root;
            for (int i = 0; i < 3; i++) begin
                r_d_prod[i] <= w_s_mag[i] * r_max_speed;
            end
        end
    end

    // divide by the root
    logic              w_q_valid;
    logic [2:0][Q-1:0] w_q_quo;
    logic [SBD-1:0]    w_q_sb;

    assign w_ctl_d = '{en: w_en, valid: r_d_valid};

    vml_div_pipe #(
        .COMPONENT_WIDTH (N),
        .SB_WIDTH        (SBD)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_d),
        .i_num   (r_d_prod),
        .i_div   (r_d_root),
        .i_sb    ({r_d_lim, r_d_neg, r_d_raw}),
        .o_valid (w_q_valid),
        .o_quo   (w_q_quo),
        .o_sb    (w_q_sb)
    );

    // stage E: output register, reapply sign or pass through
    logic           r_e_valid;
    logic           r_e_lim;
    logic [3*N-1:0] r_e_data;
    logic [3*N-1:0] n_e_data;
    logic [N-1:0]   n_qx;

    always_comb begin
        n_e_data = w_q_sb[3*N-1:0];
        n_qx     = '0;
        if (w_q_sb[3*N+3]) begin
            for (int i = 0; i < 3; i++) begin
                n_qx = N'(w_q_quo[i]);
                n_e_data[i*N +: N] = w_q_sb[3*N+i] ? (~n_qx + N'(1)) : n_qx;
            end
        end
    end

    assign w_ctl_a = '{en: w_en, valid: w_q_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_ctl_a.en) begin
            r_e_valid <= w_ctl_a.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_lim  <= w_q_sb[3*N+3];
            r_e_data <= n_e_data;
        end
    end

    assign o_m_axis_tvalid = r_e_valid;
    assign o_m_axis_tdata  = DW'(r_e_data);
    assign o_m_axis_tuser  = r_e_lim;

    // checks
    a_lim_needs_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_lim) |-> (r_max_speed != '0))
        else $error("limit flag set with limit disabled");

    a_lim_nonzero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_lim) |-> (r_c_sum != '0))
        else $error("limit flag set on zero vector");

    a_root_ge_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && r_d_lim) |-> ((N)'(r_max_speed) <= r_d_root))
        else $error("root below limit on limited vector");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(r_d_valid) && $stable(r_c_valid)))
        else $error("pipeline moved during stall");

endmodule
// ----------------------------------------------------------------------------
